// ----- hdl/wjm_pkg.sv -----
package wjm_pkg;

  localparam logic [1:0] OP_LOAD_A  = 2'd0;
  localparam logic [1:0] OP_LOAD_B  = 2'd1;
  localparam logic [1:0] OP_COMPUTE = 2'd2;

  localparam int unsigned IDENT_W  = 32;
  localparam int unsigned WEIGHT_W = 32;
  localparam int unsigned RATIO_W  = 17;

  // ratio of 1.0 in Q1.16
  localparam logic [RATIO_W-1:0] RATIO_ONE = 17'h10000;

  // one integer bit, then sixteen fraction bits
  localparam logic [4:0] DIV_LAST = 5'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic walk_clear;
    logic walk_step;
    logic div_start;
    logic div_step;
    logic publish;
  } cmd_t;

  typedef struct packed {
    logic walk_done;
    logic div_last;
  } status_t;

endpackage

// ----- hdl/weighted_jaccard_merge.sv -----
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  op, edge_ident, edge_length
// out      output     out_valid / out_stall ratio, overflowed
//
// A load transaction writes its entry when taken (or flags overflow when full).
// A compute transaction then spends up to (entries in A + entries in B) merge
// steps, sees the walk finish, runs the divider for all 17 quotient bits and
// publishes once the output is free; the next transaction can be taken in the
// cycle after the publish. in_stall is high while a compute is in progress.
// Synchronous reset clears the list counts, the overflow flag and out_valid;
// no clearing pass is needed. A stalled result holds the last step until taken.
module weighted_jaccard_merge #(
  parameter int unsigned LIST_DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    op,
  input  logic [wjm_pkg::IDENT_W-1:0]   edge_ident,
  input  logic [wjm_pkg::WEIGHT_W-1:0]  edge_length,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [wjm_pkg::RATIO_W-1:0]   ratio,
  output logic                          overflowed
);
  import wjm_pkg::*;

  cmd_t    cmd;
  status_t status;

  wjm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  wjm_dp #(
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .edge_ident  (edge_ident),
    .edge_length (edge_length),
    .ratio       (ratio),
    .overflowed  (overflowed)
  );

endmodule

// ----- hdl/wjm_ctrl.sv -----
module wjm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       op,
  output logic             out_valid,
  input  logic             out_stall,
  input  wjm_pkg::status_t status,
  output wjm_pkg::cmd_t    cmd
);
  import wjm_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   in_take;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != ST_IDLE);
  assign in_take  = in_valid && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_take) begin
          cmd.load_a = (op == OP_LOAD_A);
          cmd.load_b = (op == OP_LOAD_B);
          if (op == OP_COMPUTE) begin
            cmd.walk_clear = 1'b1;
            state_next     = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (status.walk_done) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- hdl/wjm_dp.sv -----
module wjm_dp #(
  parameter int unsigned LIST_DEPTH = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  wjm_pkg::cmd_t                  cmd,
  output wjm_pkg::status_t               status,
  input  logic [wjm_pkg::IDENT_W-1:0]    edge_ident,
  input  logic [wjm_pkg::WEIGHT_W-1:0]   edge_length,
  output logic [wjm_pkg::RATIO_W-1:0]    ratio,
  output logic                           overflowed
);
  import wjm_pkg::*;

  localparam int unsigned IDX_W   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned CNT_W   = $clog2(LIST_DEPTH + 1);
  localparam int unsigned SUM_W   = WEIGHT_W + CNT_W + 1;
  localparam int unsigned ENTRY_W = IDENT_W + WEIGHT_W;

  logic [ENTRY_W-1:0] mem_a [LIST_DEPTH];
  logic [ENTRY_W-1:0] mem_b [LIST_DEPTH];
  logic [ENTRY_W-1:0] rd_a;
  logic [ENTRY_W-1:0] rd_b;

  logic [CNT_W-1:0] count_a;
  logic [CNT_W-1:0] count_b;
  logic             overflow_seen;

  logic [CNT_W-1:0] ia;
  logic [CNT_W-1:0] ib;
  logic [CNT_W-1:0] ia_next;
  logic [CNT_W-1:0] ib_next;

  logic [SUM_W-1:0] inter;
  logic [SUM_W-1:0] uni;
  logic [SUM_W-1:0] inter_next;
  logic [SUM_W-1:0] uni_next;

  logic [SUM_W-1:0]   rem;
  logic [SUM_W:0]     trial;
  logic               fits;
  logic [RATIO_W-1:0] quo;
  logic [4:0]         div_cnt;

  logic a_live;
  logic b_live;
  logic [IDENT_W-1:0]  id_a;
  logic [IDENT_W-1:0]  id_b;
  logic [WEIGHT_W-1:0] w_a;
  logic [WEIGHT_W-1:0] w_b;
  logic full_a;
  logic full_b;

  assign id_a   = rd_a[ENTRY_W-1:WEIGHT_W];
  assign id_b   = rd_b[ENTRY_W-1:WEIGHT_W];
  assign w_a    = rd_a[WEIGHT_W-1:0];
  assign w_b    = rd_b[WEIGHT_W-1:0];
  assign a_live = (ia < count_a);
  assign b_live = (ib < count_b);
  assign full_a = (count_a == CNT_W'(LIST_DEPTH));
  assign full_b = (count_b == CNT_W'(LIST_DEPTH));

  assign status.walk_done = !a_live && !b_live;
  assign status.div_last  = (div_cnt == DIV_LAST);

  // merge step; read addresses follow the next index so data lines up next cycle
  always_comb begin
    ia_next    = ia;
    ib_next    = ib;
    inter_next = inter;
    uni_next   = uni;
    if (cmd.walk_clear) begin
      ia_next    = '0;
      ib_next    = '0;
      inter_next = '0;
      uni_next   = '0;
    end else if (cmd.walk_step) begin
      priority if (a_live && b_live && (id_a < id_b)) begin
        uni_next = uni + SUM_W'(w_a);
        ia_next  = ia + 1'b1;
      end else if (a_live && b_live && (id_b < id_a)) begin
        uni_next = uni + SUM_W'(w_b);
        ib_next  = ib + 1'b1;
      end else if (a_live && b_live) begin
        inter_next = inter + SUM_W'(w_a);
        uni_next   = uni + SUM_W'(w_a);
        ia_next    = ia + 1'b1;
        ib_next    = ib + 1'b1;
      end else if (a_live) begin
        uni_next = uni + SUM_W'(w_a);
        ia_next  = ia + 1'b1;
      end else if (b_live) begin
        uni_next = uni + SUM_W'(w_b);
        ib_next  = ib + 1'b1;
      end else begin
        uni_next = uni;
      end
    end
  end

  // first quotient bit compares without the shift
  assign trial = (div_cnt == '0) ? {1'b0, rem} : {rem, 1'b0};
  assign fits  = (trial >= {1'b0, uni});

  always_ff @(posedge clk) begin
    rd_a <= mem_a[ia_next[IDX_W-1:0]];
    rd_b <= mem_b[ib_next[IDX_W-1:0]];
    if (cmd.load_a && !full_a) begin
      mem_a[count_a[IDX_W-1:0]] <= {edge_ident, edge_length};
    end
    if (cmd.load_b && !full_b) begin
      mem_b[count_b[IDX_W-1:0]] <= {edge_ident, edge_length};
    end
  end

  always_ff @(posedge clk) begin
    ia    <= ia_next;
    ib    <= ib_next;
    inter <= inter_next;
    uni   <= uni_next;
    if (cmd.div_start) begin
      rem     <= inter;
      quo     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem     <= fits ? SUM_W'(trial - {1'b0, uni}) : trial[SUM_W-1:0];
      quo     <= {quo[RATIO_W-2:0], fits};
      div_cnt <= div_cnt + 1'b1;
    end
    if (cmd.publish) begin
      priority if (count_a == '0 && count_b == '0) begin
        ratio <= RATIO_ONE;
      end else if (uni == '0) begin
        ratio <= '0;
      end else begin
        ratio <= quo;
      end
      overflowed <= overflow_seen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_a       <= '0;
      count_b       <= '0;
      overflow_seen <= 1'b0;
    end else if (cmd.publish) begin
      count_a       <= '0;
      count_b       <= '0;
      overflow_seen <= 1'b0;
    end else begin
      if (cmd.load_a) begin
        if (full_a) begin
          overflow_seen <= 1'b1;
        end else begin
          count_a <= count_a + 1'b1;
        end
      end
      if (cmd.load_b) begin
        if (full_b) begin
          overflow_seen <= 1'b1;
        end else begin
          count_b <= count_b + 1'b1;
        end
      end
    end
  end

endmodule
